// ===== rtl/core/exposure_parameter_sweep_sequencer_defines.svh =====
// Assertion macros for the exposure parameter sweep sequencer.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef EXPOSURE_PARAMETER_SWEEP_SEQUENCER_DEFINES_SVH
`define EXPOSURE_PARAMETER_SWEEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define EPSS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epss: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define EPSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epss: next-cycle check failed");

`endif

// ===== rtl/core/epss_pkg.sv =====
// Shared types and constants of the exposure parameter sweep sequencer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package epss_pkg;

    // Default sizing, handed to the top-level parameters
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VALUE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int REQ_W       = 2;
    localparam int INDEX_W     = 6;
    localparam int PORT_VAL_W  = 16;
    localparam int STATUS_W    = 3;
    localparam int LOOP_W      = 16;
    localparam int ROUND_W     = 24;
    localparam int REPEAT_W    = 16;
    localparam int ENTRIES_W   = 7;
    localparam int SWEEP_W     = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 48;

    localparam logic [ROUND_W-1:0] ROUND_MAX = '1;
    localparam logic [LOOP_W-1:0]  LOOP_MAX  = '1;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CUSTOM_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_COUNT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_ENTRIES  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLT_SWEEP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_SWEEP  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DURATION_SWEEP = 3'd5;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_WORKING   = 3'd0,
        ST_NEW_ROUND = 3'd1,
        ST_LAST_ONE  = 3'd2,
        ST_COMPLETE  = 3'd3,
        ST_ACCEPTED  = 3'd4
    } status_t;

endpackage

// ===== rtl/core/epss_channels.sv =====
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on epss_pkg for field widths.
`timescale 1ns / 1ps

interface epss_req_if import epss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [REQ_W-1:0]      req_type;
    logic [INDEX_W-1:0]    entry_index;
    logic [PORT_VAL_W-1:0] entry_volt_kv;
    logic [PORT_VAL_W-1:0] entry_current_ua;
    logic [PORT_VAL_W-1:0] entry_duration_ms;

    modport source (output valid, req_type, entry_index, entry_volt_kv,
                    entry_current_ua, entry_duration_ms, input ready);
    modport sink   (input valid, req_type, entry_index, entry_volt_kv,
                    entry_current_ua, entry_duration_ms, output ready);
endinterface

interface epss_rsp_if import epss_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [PORT_VAL_W-1:0] volt_kv;
    logic [PORT_VAL_W-1:0] current_ua;
    logic [PORT_VAL_W-1:0] duration_ms;
    logic [LOOP_W-1:0]     loop_index;
    logic [ROUND_W-1:0]    round_index;

    modport source (output valid, status, volt_kv, current_ua, duration_ms,
                    loop_index, round_index, input ready);
    modport sink   (input valid, status, volt_kv, current_ua, duration_ms,
                    loop_index, round_index, output ready);
endinterface

interface epss_cfg_if import epss_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/epss_axis_step.sv =====
// One sweep axis: step by the signed step, clamp to the end, wrap to the start.
// Depends on epss_pkg for the sweep word layout.
`timescale 1ns / 1ps

module epss_axis_step
    import epss_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic [VALUE_WIDTH-1:0] cur,
    input  logic [SWEEP_W-1:0]     sweep,
    output logic [VALUE_WIDTH-1:0] nxt,
    output logic                   carry
);

    // Signed working width covers the value range plus a 16-bit step
    localparam int SW = ((VALUE_WIDTH > 16) ? VALUE_WIDTH : 16) + 2;

    logic [VALUE_WIDTH-1:0] start_val;
    logic [VALUE_WIDTH-1:0] end_val;
    logic signed [SW-1:0]   cur_s;
    logic signed [SW-1:0]   end_s;
    logic signed [SW-1:0]   step_s;
    logic signed [SW-1:0]   sum_s;
    logic [VALUE_WIDTH-1:0] moved;

    // Unpack start and end, sign-extend the step
    assign start_val = VALUE_WIDTH'(sweep[15:0]);
    assign end_val   = VALUE_WIDTH'(sweep[31:16]);
    assign cur_s     = $signed(SW'(cur));
    assign end_s     = $signed(SW'(end_val));
    assign step_s    = SW'($signed(sweep[47:32]));
    assign sum_s     = cur_s + step_s;

    // Clamp toward the end in the direction of the step
    always_comb
    begin
        if (step_s >= 0)
        begin
            moved = (sum_s >= end_s) ? end_val : VALUE_WIDTH'(sum_s);
        end
        else
        begin
            moved = (sum_s < end_s) ? end_val : VALUE_WIDTH'(sum_s);
        end
    end

    // Wrap from the end back to the start; landing on the start carries
    assign nxt   = (cur == end_val) ? start_val : moved;
    assign carry = (nxt == start_val);

endmodule

// ===== rtl/core/exposure_parameter_sweep_sequencer.sv =====
// Exposure parameter sweep sequencer: one request in, one result out.
// Path: input register on transfer, then the result register.
// Throughput: one request per cycle while rsp.ready holds, via the single input-to-result pass.
// Custom-mode setpoints come from the triple table's registered read port.
// Reset (rst_n low, asynchronous) clears the run state and config; the table keeps
// whatever it held and needs no clearing pass.
`timescale 1ns / 1ps
`include "exposure_parameter_sweep_sequencer_defines.svh"

module exposure_parameter_sweep_sequencer
    import epss_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    epss_req_if.sink    req,
    epss_rsp_if.source  rsp,
    epss_cfg_if.sink    cfg
);

    localparam int VW   = VALUE_WIDTH;
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW   = ($clog2(TABLE_DEPTH + 1) > ENTRIES_W) ?
                          $clog2(TABLE_DEPTH + 1) : ENTRIES_W;
    localparam int PW   = ROUND_W + 1;
    localparam int LW   = LOOP_W + 1;

    // Configuration registers
    logic                 custom_mode_reg;
    logic [REPEAT_W-1:0]  repeat_count_reg;
    logic [ENTRIES_W-1:0] table_entries_reg;
    logic [SWEEP_W-1:0]   volt_sweep_reg;
    logic [SWEEP_W-1:0]   current_sweep_reg;
    logic [SWEEP_W-1:0]   duration_sweep_reg;

    // Input register
    logic                  in_valid_reg;
    logic [REQ_W-1:0]      in_req_reg;
    logic [INDEX_W-1:0]    in_index_reg;
    logic [PORT_VAL_W-1:0] in_volt_reg;
    logic [PORT_VAL_W-1:0] in_current_reg;
    logic [PORT_VAL_W-1:0] in_duration_reg;

    // Run state
    logic               started_reg,  started_next;
    logic               finished_reg, finished_next;
    logic [ROUND_W-1:0] round_reg,    round_next;
    logic [LOOP_W-1:0]  loop_reg,     loop_next;
    logic [VW-1:0]      sp_volt_reg,  sp_volt_next;
    logic [VW-1:0]      sp_cur_reg,   sp_cur_next;
    logic [VW-1:0]      sp_dur_reg,   sp_dur_next;
    logic               sp_mem_reg,   sp_mem_next;

    // Result register
    logic               out_valid_reg;
    status_t            out_status_reg;
    status_t            status_next;
    logic [VW-1:0]      out_volt_reg;
    logic [VW-1:0]      out_cur_reg;
    logic [VW-1:0]      out_dur_reg;
    logic               out_mem_reg;
    logic [LOOP_W-1:0]  out_loop_reg;
    logic [ROUND_W-1:0] out_round_reg;

    // Triple table
    logic [3*VW-1:0] mem [TABLE_DEPTH];
    logic [3*VW-1:0] rd_data_reg;
    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;

    // Handshake
    logic stage_ready;
    logic fire;

    // Effective setpoints and axis results
    logic [VW-1:0] volt_now, cur_now, dur_now;
    logic [VW-1:0] volt_step, cur_step, dur_step;
    logic          volt_carry, cur_carry, dur_carry;
    logic [VW-1:0] volt_start, cur_start, dur_start;
    logic [VW-1:0] volt_end, cur_end, dur_end;

    // Counter helpers
    logic [LW-1:0]     rep_ext;
    logic [LW-1:0]     loop_inc;
    logic [LOOP_W-1:0] loop_sat;
    logic [LW-1:0]     loop_sat_inc;
    logic              loop_done;
    logic [ROUND_W-1:0] round_inc;
    logic [NW-1:0]     n_entries;
    logic [PW-1:0]     pos;
    logic [PW-1:0]     pos_eff;
    logic              wrap;
    logic              last_after;
    logic [VW-1:0]     new_volt, new_cur, new_dur;
    logic              at_ends;

    // Move items through on transfer
    assign stage_ready = !out_valid_reg || rsp.ready;
    assign fire        = in_valid_reg && stage_ready;
    assign req.ready   = !in_valid_reg || fire;
    assign cfg.ready   = 1'b1;

    // Setpoints as last updated: a pending table read overrides the register
    assign volt_now = sp_mem_reg ? rd_data_reg[VW-1:0]      : sp_volt_reg;
    assign cur_now  = sp_mem_reg ? rd_data_reg[2*VW-1:VW]   : sp_cur_reg;
    assign dur_now  = sp_mem_reg ? rd_data_reg[3*VW-1:2*VW] : sp_dur_reg;

    assign volt_start = VW'(volt_sweep_reg[15:0]);
    assign cur_start  = VW'(current_sweep_reg[15:0]);
    assign dur_start  = VW'(duration_sweep_reg[15:0]);
    assign volt_end   = VW'(volt_sweep_reg[31:16]);
    assign cur_end    = VW'(current_sweep_reg[31:16]);
    assign dur_end    = VW'(duration_sweep_reg[31:16]);

    epss_axis_step #(.VALUE_WIDTH(VW)) u_axis_dur
    (
        .cur   (dur_now),
        .sweep (duration_sweep_reg),
        .nxt   (dur_step),
        .carry (dur_carry)
    );

    epss_axis_step #(.VALUE_WIDTH(VW)) u_axis_cur
    (
        .cur   (cur_now),
        .sweep (current_sweep_reg),
        .nxt   (cur_step),
        .carry (cur_carry)
    );

    epss_axis_step #(.VALUE_WIDTH(VW)) u_axis_volt
    (
        .cur   (volt_now),
        .sweep (volt_sweep_reg),
        .nxt   (volt_step),
        .carry (volt_carry)
    );

    // Loop and round counting
    assign rep_ext      = {1'b0, repeat_count_reg};
    assign loop_inc     = {1'b0, loop_reg} + LW'(1);
    assign loop_sat     = loop_inc[LOOP_W] ? LOOP_MAX : loop_inc[LOOP_W-1:0];
    assign loop_sat_inc = {1'b0, loop_sat} + LW'(1);
    assign loop_done    = (loop_inc >= rep_ext);
    assign round_inc    = (round_reg < ROUND_MAX) ? round_reg + ROUND_W'(1) : round_reg;

    // Clamp the table count to the table depth
    assign n_entries = (NW'(table_entries_reg) > NW'(TABLE_DEPTH)) ?
                       NW'(TABLE_DEPTH) : NW'(table_entries_reg);

    // Odometer: duration fastest, then current, then voltage
    assign new_dur  = dur_step;
    assign new_cur  = dur_carry ? cur_step : cur_now;
    assign new_volt = (dur_carry && cur_carry) ? volt_step : volt_now;
    assign at_ends  = (new_volt == volt_end) && (new_cur == cur_end) && (new_dur == dur_end);

    // Fold the 6-bit load slot onto the table depth
    always_comb
    begin
        wr_addr = '0;
        for (int k = 0; k < (1 << INDEX_W); k++)
        begin
            if (in_index_reg == INDEX_W'(k))
            begin
                wr_addr = AW'(k % TABLE_DEPTH);
            end
        end
    end

    // Work out the next state and result of the registered request
    always_comb
    begin
        started_next  = started_reg;
        finished_next = finished_reg;
        round_next    = round_reg;
        loop_next     = loop_reg;
        sp_volt_next  = sp_volt_reg;
        sp_cur_next   = sp_cur_reg;
        sp_dur_next   = sp_dur_reg;
        sp_mem_next   = sp_mem_reg;
        status_next   = ST_ACCEPTED;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        rd_addr       = '0;
        pos           = started_reg ? {1'b0, round_reg} + PW'(1) : '0;
        wrap          = (pos >= PW'(n_entries));
        pos_eff       = wrap ? '0 : pos;
        last_after    = wrap ? (loop_sat_inc >= rep_ext) : loop_done;

        if (fire)
        begin
            case (in_req_reg)
                REQ_RESTART:
                begin
                    started_next  = 1'b0;
                    finished_next = 1'b0;
                    round_next    = '0;
                    loop_next     = '0;
                    sp_volt_next  = '0;
                    sp_cur_next   = '0;
                    sp_dur_next   = '0;
                    sp_mem_next   = 1'b0;
                end
                REQ_LOAD:
                begin
                    mem_we = 1'b1;
                end
                REQ_ADVANCE:
                begin
                    if (finished_reg)
                    begin
                        status_next = ST_COMPLETE;
                    end
                    else if (custom_mode_reg)
                    begin
                        // Walk the loaded table
                        if (n_entries == '0)
                        begin
                            finished_next = 1'b1;
                            status_next   = ST_COMPLETE;
                        end
                        else if (wrap && loop_done)
                        begin
                            started_next  = 1'b1;
                            round_next    = (pos > PW'(ROUND_MAX)) ? ROUND_MAX
                                                                  : pos[ROUND_W-1:0];
                            loop_next     = loop_sat;
                            finished_next = 1'b1;
                            status_next   = ST_COMPLETE;
                        end
                        else
                        begin
                            started_next = 1'b1;
                            if (wrap)
                            begin
                                loop_next = loop_sat;
                            end
                            round_next  = pos_eff[ROUND_W-1:0];
                            mem_re      = 1'b1;
                            rd_addr     = pos_eff[AW-1:0];
                            sp_mem_next = 1'b1;
                            if ((pos_eff + PW'(1) >= PW'(n_entries)) && last_after)
                            begin
                                status_next = ST_LAST_ONE;
                            end
                            else if (pos_eff == '0)
                            begin
                                status_next = ST_NEW_ROUND;
                            end
                            else
                            begin
                                status_next = ST_WORKING;
                            end
                        end
                    end
                    else if (!started_reg)
                    begin
                        // First triple of a regular sweep
                        started_next = 1'b1;
                        round_next   = '0;
                        sp_volt_next = volt_start;
                        sp_cur_next  = cur_start;
                        sp_dur_next  = dur_start;
                        sp_mem_next  = 1'b0;
                        status_next  = (loop_done && (volt_start == volt_end) &&
                                        (cur_start == cur_end) && (dur_start == dur_end)) ?
                                       ST_LAST_ONE : ST_NEW_ROUND;
                    end
                    else
                    begin
                        // Step the odometer
                        sp_volt_next = new_volt;
                        sp_cur_next  = new_cur;
                        sp_dur_next  = new_dur;
                        sp_mem_next  = 1'b0;
                        if (!(dur_carry && cur_carry && volt_carry))
                        begin
                            round_next  = round_inc;
                            status_next = (loop_done && at_ends) ? ST_LAST_ONE : ST_WORKING;
                        end
                        else if (loop_done)
                        begin
                            round_next    = round_inc;
                            loop_next     = loop_sat;
                            finished_next = 1'b1;
                            status_next   = ST_COMPLETE;
                        end
                        else
                        begin
                            round_next  = '0;
                            loop_next   = loop_sat;
                            status_next = ((loop_sat_inc >= rep_ext) && at_ends) ?
                                          ST_LAST_ONE : ST_NEW_ROUND;
                        end
                    end
                end
                default:
                begin
                    status_next = ST_ACCEPTED;
                end
            endcase
        end
    end

    // Hold configuration; writes to unlisted indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            custom_mode_reg    <= 1'b0;
            repeat_count_reg   <= REPEAT_W'(1);
            table_entries_reg  <= '0;
            volt_sweep_reg     <= '0;
            current_sweep_reg  <= '0;
            duration_sweep_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_CUSTOM_MODE:    custom_mode_reg    <= cfg.data[0];
                CFG_REPEAT_COUNT:   repeat_count_reg   <= cfg.data[REPEAT_W-1:0];
                CFG_TABLE_ENTRIES:  table_entries_reg  <= cfg.data[ENTRIES_W-1:0];
                CFG_VOLT_SWEEP:     volt_sweep_reg     <= cfg.data[SWEEP_W-1:0];
                CFG_CURRENT_SWEEP:  current_sweep_reg  <= cfg.data[SWEEP_W-1:0];
                CFG_DURATION_SWEEP: duration_sweep_reg <= cfg.data[SWEEP_W-1:0];
                default:            ;
            endcase
        end
    end

    // Capture a request on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_req_reg      <= req.req_type;
            in_index_reg    <= req.entry_index;
            in_volt_reg     <= req.entry_volt_kv;
            in_current_reg  <= req.entry_current_ua;
            in_duration_reg <= req.entry_duration_ms;
        end
    end

    // Advance the run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            round_reg    <= '0;
            loop_reg     <= '0;
            sp_volt_reg  <= '0;
            sp_cur_reg   <= '0;
            sp_dur_reg   <= '0;
            sp_mem_reg   <= 1'b0;
        end
        else
        begin
            started_reg  <= started_next;
            finished_reg <= finished_next;
            round_reg    <= round_next;
            loop_reg     <= loop_next;
            sp_volt_reg  <= sp_volt_next;
            sp_cur_reg   <= sp_cur_next;
            sp_dur_reg   <= sp_dur_next;
            sp_mem_reg   <= sp_mem_next;
        end
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {VW'(in_duration_reg), VW'(in_current_reg), VW'(in_volt_reg)};
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg <= status_next;
            out_volt_reg   <= sp_volt_next;
            out_cur_reg    <= sp_cur_next;
            out_dur_reg    <= sp_dur_next;
            out_mem_reg    <= sp_mem_next;
            out_loop_reg   <= loop_next;
            out_round_reg  <= round_next;
        end
    end

    // Drive the response; table setpoints come from the read register
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.volt_kv     = PORT_VAL_W'(out_mem_reg ? rd_data_reg[VW-1:0] : out_volt_reg);
    assign rsp.current_ua  = PORT_VAL_W'(out_mem_reg ? rd_data_reg[2*VW-1:VW] : out_cur_reg);
    assign rsp.duration_ms = PORT_VAL_W'(out_mem_reg ? rd_data_reg[3*VW-1:2*VW] : out_dur_reg);
    assign rsp.loop_index  = out_loop_reg;
    assign rsp.round_index = out_round_reg;

    // Checks
    `EPSS_ASSERT_NEXT(a_done_holds, fire && (in_req_reg == REQ_ADVANCE) && finished_reg, out_status_reg == ST_COMPLETE)
    `EPSS_ASSERT_NEXT(a_restart_clears, fire && (in_req_reg == REQ_RESTART), !started_reg && !finished_reg && (round_reg == '0) && (loop_reg == '0))
    `EPSS_ASSERT_NEXT(a_load_accepted, fire && (in_req_reg == REQ_LOAD), out_valid_reg && (out_status_reg == ST_ACCEPTED))
    `EPSS_ASSERT_IMPLIES(a_table_sp_started, sp_mem_reg, started_reg)

endmodule

// ===== sim/epss_setpoint_checker.sv =====
// Result checker for the exposure parameter sweep sequencer.
// Watches the request, response and register-write channels (epss_channels.sv, epss_pkg).
// Predicts each setpoint report and compares it with what the block returns.
`timescale 1ns / 1ps

module epss_setpoint_checker
    import epss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    epss_req_if  req,
    epss_rsp_if  rsp,
    epss_cfg_if  cfg,
    output int   mismatches,
    output int   awaiting,
    output int   requests,
    output int   advances,
    output int   completions,
    output int   table_steps
);

    localparam int REPORT_CAP = 40;

    typedef struct packed {
        status_t               status;
        logic [PORT_VAL_W-1:0] volt_kv;
        logic [PORT_VAL_W-1:0] current_ua;
        logic [PORT_VAL_W-1:0] duration_ms;
        logic [LOOP_W-1:0]     loop_index;
        logic [ROUND_W-1:0]    round_index;
    } setpoint_report_t;

    // Register copies
    logic                 mode_custom;
    logic [REPEAT_W-1:0]  repeat_cnt;
    logic [ENTRIES_W-1:0] entry_cnt;
    logic [SWEEP_W-1:0]   volt_cfg;
    logic [SWEEP_W-1:0]   cur_cfg;
    logic [SWEEP_W-1:0]   dur_cfg;

    // Run state of the sequence
    bit                    run_started;
    bit                    run_finished;
    int unsigned           round_pos;
    int unsigned           loop_pos;
    logic [PORT_VAL_W-1:0] sp_volt;
    logic [PORT_VAL_W-1:0] sp_cur;
    logic [PORT_VAL_W-1:0] sp_dur;
    logic [SWEEP_W-1:0]    triples [TABLE_DEPTH_DEF];

    setpoint_report_t report_q [$];

    function automatic void clear_run();
        run_started  = 1'b0;
        run_finished = 1'b0;
        round_pos    = 0;
        loop_pos     = 0;
        sp_volt      = '0;
        sp_cur       = '0;
        sp_dur       = '0;
    endfunction

    // Move one axis toward its end, clamp, wrap at the end; report landing on start
    function automatic bit axis_move(inout logic [PORT_VAL_W-1:0] pos,
                                     input logic [SWEEP_W-1:0] sweep);
        int lo;
        int hi;
        int stp;
        int c;
        lo  = int'(sweep[15:0]);
        hi  = int'(sweep[31:16]);
        stp = int'($signed(sweep[47:32]));
        c   = int'(pos);
        if (c == hi)
            c = lo;
        else
        begin
            c = c + stp;
            if (stp >= 0)
            begin
                if (c >= hi)
                    c = hi;
            end
            else if (c < hi)
                c = hi;
        end
        pos = c[PORT_VAL_W-1:0];
        return c == lo;
    endfunction

    function automatic bit on_final_loop();
        return loop_pos + 1 >= repeat_cnt;
    endfunction

    function automatic bit at_sweep_end();
        return on_final_loop() && sp_volt == volt_cfg[31:16]
            && sp_cur == cur_cfg[31:16] && sp_dur == dur_cfg[31:16];
    endfunction

    // Count one finished loop; true once the repeat count is used up
    function automatic bit close_loop();
        int unsigned nxt;
        bit          done;
        nxt      = loop_pos + 1;
        done     = nxt >= repeat_cnt;
        loop_pos = (nxt > LOOP_MAX) ? LOOP_MAX : nxt;
        if (done)
            run_finished = 1'b1;
        return done;
    endfunction

    // Walk the loaded triple table, one entry per advance
    function automatic status_t step_table();
        int unsigned        n;
        int unsigned        pos;
        logic [SWEEP_W-1:0] e;
        n = (entry_cnt > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : entry_cnt;
        if (n == 0)
        begin
            run_finished = 1'b1;
            return ST_COMPLETE;
        end
        pos = run_started ? round_pos + 1 : 0;
        run_started = 1'b1;
        if (pos >= n)
        begin
            round_pos = (pos > ROUND_MAX) ? ROUND_MAX : pos;
            if (close_loop())
                return ST_COMPLETE;
            pos = 0;
        end
        round_pos = pos;
        e = triples[pos % TABLE_DEPTH_DEF];
        sp_volt = e[15:0];
        sp_cur  = e[31:16];
        sp_dur  = e[47:32];
        if (pos + 1 >= n && on_final_loop())
            return ST_LAST_ONE;
        return (pos == 0) ? ST_NEW_ROUND : ST_WORKING;
    endfunction

    // Step the three axes like an odometer, duration fastest
    function automatic status_t step_sweep();
        bit carry;
        if (!run_started)
        begin
            run_started = 1'b1;
            round_pos   = 0;
            sp_volt     = volt_cfg[15:0];
            sp_cur      = cur_cfg[15:0];
            sp_dur      = dur_cfg[15:0];
            return at_sweep_end() ? ST_LAST_ONE : ST_NEW_ROUND;
        end
        if (round_pos < ROUND_MAX)
            round_pos++;
        carry = axis_move(sp_dur, dur_cfg);
        if (carry)
            carry = axis_move(sp_cur, cur_cfg);
        if (carry)
            carry = axis_move(sp_volt, volt_cfg);
        if (!carry)
            return at_sweep_end() ? ST_LAST_ONE : ST_WORKING;
        if (close_loop())
            return ST_COMPLETE;
        round_pos = 0;
        return at_sweep_end() ? ST_LAST_ONE : ST_NEW_ROUND;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        status_t          reply;
        setpoint_report_t want;
        if (!rst_n)
        begin
            mode_custom = 1'b0;
            repeat_cnt  = REPEAT_W'(1);
            entry_cnt   = '0;
            volt_cfg    = '0;
            cur_cfg     = '0;
            dur_cfg     = '0;
            clear_run();
            report_q.delete();
            mismatches  <= 0;
            awaiting    <= 0;
            requests    <= 0;
            advances    <= 0;
            completions <= 0;
            table_steps <= 0;
        end
        else
        begin
            // Mirror register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_CUSTOM_MODE:    mode_custom = cfg.data[0];
                    CFG_REPEAT_COUNT:   repeat_cnt  = cfg.data[REPEAT_W-1:0];
                    CFG_TABLE_ENTRIES:  entry_cnt   = cfg.data[ENTRIES_W-1:0];
                    CFG_VOLT_SWEEP:     volt_cfg    = cfg.data;
                    CFG_CURRENT_SWEEP:  cur_cfg     = cfg.data;
                    CFG_DURATION_SWEEP: dur_cfg     = cfg.data;
                    default: ;
                endcase
            end

            // Predict the report for each request transfer
            if (req.valid && req.ready)
            begin
                reply = ST_ACCEPTED;
                case (req.req_type)
                    REQ_RESTART: clear_run();
                    REQ_LOAD:
                        triples[req.entry_index] = {req.entry_duration_ms,
                                                    req.entry_current_ua,
                                                    req.entry_volt_kv};
                    REQ_ADVANCE:
                    begin
                        if (run_finished)
                            reply = ST_COMPLETE;
                        else if (mode_custom)
                        begin
                            reply = step_table();
                            table_steps <= table_steps + 1;
                        end
                        else
                            reply = step_sweep();
                        advances <= advances + 1;
                        if (reply == ST_COMPLETE)
                            completions <= completions + 1;
                    end
                    default: ;
                endcase
                report_q.push_back('{reply, sp_volt, sp_cur, sp_dur,
                                     loop_pos[LOOP_W-1:0], round_pos[ROUND_W-1:0]});
                requests <= requests + 1;
            end

            // Compare each response transfer with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (report_q.size() == 0)
                begin
                    if (mismatches < REPORT_CAP)
                        $display("%0t: unexpected result status %0d kV %0d uA %0d ms %0d",
                                 $time, rsp.status, rsp.volt_kv, rsp.current_ua,
                                 rsp.duration_ms);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = report_q.pop_front();
                    if (rsp.status !== want.status || rsp.volt_kv !== want.volt_kv
                        || rsp.current_ua !== want.current_ua
                        || rsp.duration_ms !== want.duration_ms
                        || rsp.loop_index !== want.loop_index
                        || rsp.round_index !== want.round_index)
                    begin
                        if (mismatches < REPORT_CAP)
                            $display({"%0t: result mismatch: expected status %0d kV %0d ",
                                      "uA %0d ms %0d loop %0d round %0d, got status %0d ",
                                      "kV %0d uA %0d ms %0d loop %0d round %0d"},
                                     $time, want.status, want.volt_kv, want.current_ua,
                                     want.duration_ms, want.loop_index, want.round_index,
                                     rsp.status, rsp.volt_kv, rsp.current_ua,
                                     rsp.duration_ms, rsp.loop_index, rsp.round_index);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            awaiting <= report_q.size();
        end
    end

endmodule

// ===== sim/exposure_parameter_sweep_sequencer_tb.sv =====
// Top of the sweep sequencer testbench: clock, reset, request and register stimulus.
// Depends on epss_pkg, epss_channels.sv, the sequencer RTL and epss_setpoint_checker.
`timescale 1ns / 1ps

module exposure_parameter_sweep_sequencer_tb;
    import epss_pkg::*;

    localparam logic [REQ_W-1:0]       REQ_SPARE   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE   = 3'd7;
    localparam int                     ITEM_TARGET = 1800;
    localparam int                     HOLD_CYCLES = 400;
    localparam int                     DRAIN_LIMIT = 5000;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_go;
    logic hold_active;

    int tx_idle_pct;
    int rx_stall_pct;
    int items_sent;
    int settings;
    bit drain_stuck;
    bit slot_ok [TABLE_DEPTH_DEF];

    int mismatches;
    int awaiting;
    int requests;
    int advances;
    int completions;
    int table_steps;

    epss_req_if req ();
    epss_rsp_if rsp ();
    epss_cfg_if cfg ();

    exposure_parameter_sweep_sequencer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    epss_setpoint_checker setpoint_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .awaiting    (awaiting),
        .requests    (requests),
        .advances    (advances),
        .completions (completions),
        .table_steps (table_steps)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Drop ready at random, and fully during the hold-off
    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= !hold_active && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Hold the receiver off for a long stretch once, so the block backs up
    initial
    begin
        hold_active <= 1'b0;
        wait (hold_go === 1'b1);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Offer one request and hold it until transfer
    task automatic push_req(input logic [REQ_W-1:0] kind, input logic [INDEX_W-1:0] slot,
                            input logic [15:0] kv, input logic [15:0] ua,
                            input logic [15:0] ms);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid             <= 1'b1;
        req.req_type          <= kind;
        req.entry_index       <= slot;
        req.entry_volt_kv     <= kv;
        req.entry_current_ua  <= ua;
        req.entry_duration_ms <= ms;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
        if (kind == REQ_LOAD)
            slot_ok[slot] = 1'b1;
    endtask

    // Mostly advances, with restarts, loads and the unused code mixed in
    task automatic push_random();
        int          r;
        logic [1:0]  kind;
        r = $urandom_range(0, 99);
        if (r < 82)
            kind = REQ_ADVANCE;
        else if (r < 88)
            kind = REQ_LOAD;
        else if (r < 94)
            kind = REQ_RESTART;
        else
            kind = REQ_SPARE;
        push_req(kind, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    // Wait for every outstanding report, bounded
    task automatic drain();
        int waited;
        waited = 0;
        req.valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (awaiting != 0 && waited < DRAIN_LIMIT);
        if (awaiting != 0)
            drain_stuck = 1'b1;
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
    endtask

    // Fill the bits above a register's width with noise
    function automatic logic [CFG_DATA_W-1:0] pad(input int width, input logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] noise;
        logic [CFG_DATA_W-1:0] mask;
        noise = CFG_DATA_W'({$urandom(), $urandom()});
        mask  = (48'd1 << width) - 48'd1;
        return (noise & ~mask) | (val & mask);
    endfunction

    task automatic configure(input bit custom, input logic [15:0] loops,
                             input logic [6:0] entries, input logic [47:0] vs,
                             input logic [47:0] cs, input logic [47:0] ds);
        write_reg(CFG_CUSTOM_MODE, pad(1, CFG_DATA_W'(custom)));
        write_reg(CFG_REPEAT_COUNT, pad(REPEAT_W, CFG_DATA_W'(loops)));
        write_reg(CFG_TABLE_ENTRIES, pad(ENTRIES_W, CFG_DATA_W'(entries)));
        write_reg(CFG_VOLT_SWEEP, vs);
        write_reg(CFG_CURRENT_SWEEP, cs);
        write_reg(CFG_DURATION_SWEEP, ds);
        cfg.valid <= 1'b0;
        settings++;
    endtask

    // Random axis: start, end and signed step, mostly heading toward the end
    function automatic logic [47:0] make_axis(input bit tiny);
        int         lo;
        int         hi;
        int         span;
        int         mag;
        logic [15:0] stp;
        case ($urandom_range(0, 4))
            0: lo = 0;
            1: lo = 65535;
            default: lo = $urandom_range(0, 65535);
        endcase
        span = tiny ? $urandom_range(0, 3) : $urandom_range(0, 24);
        mag  = $urandom_range(1, tiny ? 2 : 8);
        if ($urandom_range(0, 1))
            hi = (lo + span > 65535) ? 65535 : lo + span;
        else
            hi = (lo < span) ? 0 : lo - span;
        case ($urandom_range(0, 9))
            0: stp = '0;
            1: stp = 16'($urandom_range(0, 65535));
            2: stp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: stp = (hi >= lo) ? 16'(mag) : 16'(-mag);
        endcase
        return {stp, 16'(hi), 16'(lo)};
    endfunction

    function automatic logic [15:0] pick_loops();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    function automatic int loaded_prefix();
        int k;
        k = 0;
        while (k < TABLE_DEPTH_DEF && slot_ok[k])
            k++;
        return k;
    endfunction

    // Table length that only reaches loaded slots; beyond the depth in one pick of four once all are loaded
    function automatic logic [6:0] pick_entries();
        int p;
        p = loaded_prefix();
        if (p == TABLE_DEPTH_DEF && $urandom_range(0, 3) == 0)
            return 7'($urandom_range(TABLE_DEPTH_DEF, 127));
        return 7'($urandom_range(0, p));
    endfunction

    initial
    begin : stimulus
        int phase;
        int n;
        int kind;
        int p;
        bit tiny;

        // Drive everything known, then hold reset low and release it
        hold_go      = 1'b0;
        drain_stuck  = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        items_sent   = 0;
        settings     = 0;
        rst_n                 <= 1'b0;
        req.valid             <= 1'b0;
        req.req_type          <= REQ_RESTART;
        req.entry_index       <= '0;
        req.entry_volt_kv     <= '0;
        req.entry_current_ua  <= '0;
        req.entry_duration_ms <= '0;
        cfg.valid             <= 1'b0;
        cfg.index             <= CFG_CUSTOM_MODE;
        cfg.data              <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: all-zero sweep ends at once, then complete holds
        push_req(REQ_ADVANCE, 6'd0, 16'd0, 16'd0, 16'd0);
        push_req(REQ_ADVANCE, 6'd0, 16'd0, 16'd0, 16'd0);
        push_req(REQ_ADVANCE, 6'd0, 16'd0, 16'd0, 16'd0);
        push_req(REQ_SPARE, 6'h3F, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_req(REQ_LOAD, 6'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_req(REQ_LOAD, 6'd1, 16'h0000, 16'h0000, 16'h0000);
        push_req(REQ_LOAD, 6'd2, 16'hAAAA, 16'h5555, 16'hAAAA);
        push_req(REQ_LOAD, 6'd3, 16'h5555, 16'hAAAA, 16'h5555);
        drain();

        // Downward volt sweep with the most negative step, parked current, zero repeat
        write_reg(CFG_SPARE, CFG_DATA_W'({$urandom(), $urandom()}));
        configure(1'b0, 16'd0, 7'd127, {16'h8000, 16'h0000, 16'hFFFF},
                  {16'h0000, 16'h0005, 16'h0005}, {16'h0001, 16'h0002, 16'h0000});
        push_req(REQ_RESTART, 6'd0, 16'd0, 16'd0, 16'd0);
        repeat (10) push_req(REQ_ADVANCE, 6'd0, 16'd0, 16'd0, 16'd0);
        drain();

        // Four-entry table twice through, then an empty table
        configure(1'b1, 16'd2, 7'd4, make_axis(1'b1), make_axis(1'b1), make_axis(1'b1));
        push_req(REQ_RESTART, 6'd0, 16'd0, 16'd0, 16'd0);
        repeat (9) push_req(REQ_ADVANCE, 6'd0, 16'd0, 16'd0, 16'd0);
        drain();
        configure(1'b1, 16'd1, 7'd0, make_axis(1'b1), make_axis(1'b1), make_axis(1'b1));
        push_req(REQ_RESTART, 6'd0, 16'd0, 16'd0, 16'd0);
        push_req(REQ_ADVANCE, 6'd0, 16'd0, 16'd0, 16'd0);
        drain();

        // Random phases, rotating through the idle patterns
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase % 4)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 66;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 66;
                end
                default:
                begin
                    tx_idle_pct  = 28;
                    rx_stall_pct = 28;
                end
            endcase
            if (phase == 3)
                hold_go = 1'b1;

            kind = $urandom_range(0, 9);
            p = loaded_prefix();
            if (p < TABLE_DEPTH_DEF && (kind < 2 || phase == 1))
            begin
                // Load a run of consecutive slots past the loaded prefix
                n = $urandom_range(8, TABLE_DEPTH_DEF);
                for (int k = p; k < p + n && k < TABLE_DEPTH_DEF; k++)
                    push_req(REQ_LOAD, 6'(k), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            end
            else
            begin
                if (kind < 6)
                begin
                    tiny = $urandom_range(0, 2) != 0;
                    configure(1'b0, pick_loops(), 7'($urandom_range(0, 127)),
                              make_axis(tiny), make_axis(tiny), make_axis(tiny));
                    n = $urandom_range(20, 120);
                end
                else
                begin
                    configure(1'b1, pick_loops(), pick_entries(),
                              make_axis(1'b0), make_axis(1'b0), make_axis(1'b0));
                    n = $urandom_range(10, 100);
                end
                if ($urandom_range(0, 4) != 0)
                    push_req(REQ_RESTART, 6'($urandom_range(0, 63)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)));
                repeat (n) push_random();
            end
            drain();
            phase++;
        end

        repeat (4) @(posedge clk);
        $display("Covered %0d requests under %0d register settings: %0d advances, %0d custom-table steps.",
                 requests, settings, advances, table_steps);
        $display("Sweeps reported complete %0d times.", completions);
        if (mismatches == 0 && awaiting == 0 && !drain_stuck)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
